/* rtl/core/fprx_pkg.sv */
package fprx_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h06;
    localparam logic [7:0] SYNC_SECOND = 8'h85;

    // Most results one byte may cause, and so the largest usable buffer.
    localparam int RESULT_LIMIT = 32;
    localparam int CNT_W        = 6;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_LEN   = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SYNC  = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_BAD_CHECK = 2'd3
    } status_t;

    // Outcome of one received byte, handed from the framer to the output sequencer.
    typedef struct packed {
        logic               valid;
        logic               drain;
        status_t            status;
        logic [CNT_W-1:0]   count;
    } fprx_event_t;

endpackage

/* rtl/core/framed_packet_receiver_xor_unit.sv */
// Receive deframer for sync / length / XOR checksum frames.
// Input channel: one rx_byte per transfer (in_valid, in_stall). The block hunts for
// 0x06, then expects 0x85, then a length byte equal to expected_length, then that many
// payload bytes and a trailing XOR checksum seeded with the length.
// Configuration: expected_length is written by a cfg_valid / cfg_ready transfer; the
// port is always ready and should be used only while no frame is in progress.
// Output channel (out_valid, out_stall): on a good checksum each buffered payload
// byte leaves as its own transfer with byte_index, last on the final one; an empty
// frame gives a single ok status. A bad second sync, bad length or bad checksum gives
// one status transfer with last set. Every outcome returns the block to hunting.
// Throughput: one input byte per cycle while framing and in_stall is low. The payload
// sits in a synchronous buffer with a registered read, and in_stall is held during the
// drain. A status result appears in the cycle after the byte that caused it.
// When the receiver stalls, the output register holds its transfer and in_stall rises
// until it is taken. Reset returns to hunting, clears expected_length and the output;
// the payload buffer needs no clearing.
module framed_packet_receiver_xor_unit #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] expected_length,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic       has_data,
    output logic [7:0] payload_byte,
    output logic [4:0] byte_index,
    output logic       last
);
    import fprx_pkg::*;

    localparam int LIM    = (MAX_PAYLOAD < RESULT_LIMIT) ? MAX_PAYLOAD : RESULT_LIMIT;
    localparam int ADDR_W = (LIM > 1) ? $clog2(LIM) : 1;

    fprx_event_t       evt;
    logic              sink_ready;
    logic              in_accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = !sink_ready;
    assign in_accept = in_valid && sink_ready;

    fprx_frame_ctrl #(
        .LIM    (LIM),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .rx_byte    (rx_byte),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_length (expected_length),
        .evt        (evt),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    fprx_payload_buf #(
        .DEPTH  (LIM),
        .ADDR_W (ADDR_W)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fprx_out_seq #(
        .ADDR_W (ADDR_W)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (evt),
        .sink_ready   (sink_ready),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .has_data     (has_data),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last         (last)
    );

endmodule

/* rtl/core/fprx_payload_buf.sv */
module fprx_payload_buf #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/fprx_frame_ctrl.sv */
module fprx_frame_ctrl #(
    parameter int LIM    = 32,
    parameter int ADDR_W = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_accept,
    input  logic [7:0]            rx_byte,
    input  logic                  cfg_write,
    input  logic [5:0]            cfg_length,
    output fprx_pkg::fprx_event_t evt,
    output logic                  wr_en,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [7:0]            wr_data
);
    import fprx_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       csum_reg, csum_next;
    logic [5:0]       exp_len_reg;
    logic             len_ok;
    logic             body_more;

    assign len_ok    = ({2'b00, exp_len_reg} == rx_byte) && (exp_len_reg <= CNT_W'(LIM));
    assign body_more = (count_reg < exp_len_reg) && (count_reg < CNT_W'(LIM));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= '0;
        end
        else if (cfg_write)
        begin
            exp_len_reg <= cfg_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            csum_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            csum_reg  <= csum_next;
        end
    end

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        csum_next  = csum_reg;
        if (in_accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SYNC_FIRST)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == SYNC_SECOND) ? PH_LEN : PH_HUNT;
                end
                PH_LEN:
                begin
                    if (len_ok)
                    begin
                        phase_next = PH_BODY;
                        count_next = '0;
                        csum_next  = rx_byte;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY:
                begin
                    if (body_more)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        csum_next  = csum_reg ^ rx_byte;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        csum_next  = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Outputs: buffer writes and the outcome event.
    always_comb
    begin
        evt       = '0;
        wr_en     = 1'b0;
        wr_addr   = count_reg[ADDR_W-1:0];
        wr_data   = rx_byte;
        if (in_accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    evt = '0;
                end
                PH_SYNC2:
                begin
                    if (rx_byte != SYNC_SECOND)
                    begin
                        evt.valid  = 1'b1;
                        evt.status = ST_BAD_SYNC;
                    end
                end
                PH_LEN:
                begin
                    if (!len_ok)
                    begin
                        evt.valid  = 1'b1;
                        evt.status = ST_BAD_LEN;
                    end
                end
                PH_BODY:
                begin
                    if (body_more)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (rx_byte != csum_reg)
                    begin
                        evt.valid  = 1'b1;
                        evt.status = ST_BAD_CHECK;
                    end
                    else
                    begin
                        // A good checksum starts the drain; an empty frame reports a single ok status with no data.
                        evt.valid  = 1'b1;
                        evt.status = ST_OK;
                        evt.drain  = (count_reg != '0);
                        evt.count  = count_reg;
                    end
                end
                default:
                begin
                    evt = '0;
                end
            endcase
        end
    end

endmodule

/* rtl/core/fprx_out_seq.sv */
module fprx_out_seq #(
    parameter int ADDR_W = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fprx_pkg::fprx_event_t evt,
    output logic                  sink_ready,
    output logic                  rd_en,
    output logic [ADDR_W-1:0]     rd_addr,
    input  logic [7:0]            rd_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic                  has_data,
    output logic [7:0]            payload_byte,
    output logic [4:0]            byte_index,
    output logic                  last
);
    import fprx_pkg::*;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic             has_data_reg, has_data_next;
    logic [7:0]       payload_reg, payload_next;
    logic [4:0]       index_reg, index_next;
    logic             last_reg, last_next;

    logic             drain_reg, drain_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] pend_idx_reg, pend_idx_next;

    logic             out_free;
    logic             move;
    logic             issue;
    logic             pend_last;

    assign out_free   = !out_valid_reg || !out_stall;
    assign sink_ready = !drain_reg && out_free;
    // Read data sits in the buffer's output register until the output slot frees up.
    assign move       = pend_reg && out_free;
    assign issue      = drain_reg && (issue_reg != total_reg) && (!pend_reg || move);
    assign pend_last  = (pend_idx_reg + CNT_W'(1)) == total_reg;
    assign rd_en      = issue;
    assign rd_addr    = issue_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            drain_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            total_reg     <= '0;
            issue_reg     <= '0;
            pend_idx_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            drain_reg     <= drain_next;
            pend_reg      <= pend_next;
            total_reg     <= total_next;
            issue_reg     <= issue_next;
            pend_idx_reg  <= pend_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        has_data_reg <= has_data_next;
        payload_reg  <= payload_next;
        index_reg    <= index_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        has_data_next  = has_data_reg;
        payload_next   = payload_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        drain_next     = drain_reg;
        total_next     = total_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;

        if (evt.valid && evt.drain)
        begin
            drain_next = 1'b1;
            total_next = evt.count;
            issue_next = '0;
        end
        else if (evt.valid)
        begin
            out_valid_next = 1'b1;
            status_next    = evt.status;
            has_data_next  = 1'b0;
            payload_next   = '0;
            index_next     = '0;
            last_next      = 1'b1;
        end

        if (move)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            has_data_next  = 1'b1;
            payload_next   = rd_data;
            index_next     = pend_idx_reg[4:0];
            last_next      = pend_last;
            pend_next      = 1'b0;
            if (pend_last)
            begin
                drain_next = 1'b0;
            end
        end

        if (issue)
        begin
            pend_next     = 1'b1;
            pend_idx_next = issue_reg;
            issue_next    = issue_reg + CNT_W'(1);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign has_data     = has_data_reg;
    assign payload_byte = payload_reg;
    assign byte_index   = index_reg;
    assign last         = last_reg;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    import fprx_pkg::*;

    localparam int TOTAL_ITEMS   = 310;
    localparam int PHASE_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 2000;

    typedef struct {
        status_t    st;
        logic       has_data;
        logic [7:0] data;
        logic [4:0] idx;
        logic       last;
    } rx_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] expected_length = 6'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    logic       has_data;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic       last;

    // Shadow copy of the deframer state, updated on every accepted input transfer.
    phase_t     rx_phase = PH_HUNT;
    logic [5:0] taken = 6'd0;
    logic [7:0] running_xor = 8'h00;
    logic [7:0] payload_buf [RESULT_LIMIT];
    logic [5:0] cfg_length = 6'd0;

    rx_result_t pending_results [$];
    logic [7:0] frame_data [$];
    int         framed_items = 0;
    int         mismatch_count = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         stall_left = 0;
    int         idle_cycles = 0;

    framed_packet_receiver_xor_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .expected_length(expected_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .has_data       (has_data),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .last           (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic int pick_gap();
        if (gap_pct == 0 || $urandom_range(99) >= gap_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 15);
        return $urandom_range(3, 1);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned got_v);
        $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
        mismatch_count++;
    endtask

    task automatic expect_result(input status_t st, input logic hd, input logic [7:0] d,
                                 input logic [4:0] i, input logic l);
        rx_result_t r;
        r.st = st;
        r.has_data = hd;
        r.data = d;
        r.idx = i;
        r.last = l;
        pending_results.push_back(r);
    endtask

    task automatic abort_frame(input status_t code);
        rx_phase = PH_HUNT;
        taken = 6'd0;
        running_xor = 8'h00;
        expect_result(code, 1'b0, 8'h00, 5'd0, 1'b1);
    endtask

    // Advances the shadow state by one received byte and queues what it should produce.
    task automatic deframe_byte(input logic [7:0] b);
        int n;
        if (rx_phase != PH_HUNT || b == SYNC_FIRST)
            framed_items++;
        case (rx_phase)
            PH_HUNT:
            begin
                if (b == SYNC_FIRST)
                    rx_phase = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                if (b != SYNC_SECOND)
                    abort_frame(ST_BAD_SYNC);
                else
                    rx_phase = PH_LEN;
            end
            PH_LEN:
            begin
                if (b != {2'b00, cfg_length} || cfg_length > RESULT_LIMIT)
                    abort_frame(ST_BAD_LEN);
                else
                begin
                    running_xor = b;
                    taken = 6'd0;
                    rx_phase = PH_BODY;
                end
            end
            default:
            begin
                if (taken < cfg_length && taken < RESULT_LIMIT)
                begin
                    payload_buf[taken[4:0]] = b;
                    running_xor = running_xor ^ b;
                    taken = taken + 6'd1;
                end
                else if (b != running_xor)
                    abort_frame(ST_BAD_CHECK);
                else
                begin
                    n = taken;
                    if (n == 0)
                        expect_result(ST_OK, 1'b0, 8'h00, 5'd0, 1'b1);
                    for (int k = 0; k < n; k++)
                        expect_result(ST_OK, 1'b1, payload_buf[k], 5'(k), k == n - 1);
                    rx_phase = PH_HUNT;
                    taken = 6'd0;
                    running_xor = 8'h00;
                end
            end
        endcase
    endtask

    // The valid stays high after a transfer so that a back-to-back byte needs no toggle.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        deframe_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] len_byte, input bit bad_check);
        logic [7:0] check;
        logic [7:0] flip;
        check = len_byte;
        foreach (frame_data[i])
            check = check ^ frame_data[i];
        if (bad_check)
        begin
            flip = rand_byte();
            if (flip == 8'h00)
                flip = 8'h01;
            check = check ^ flip;
        end
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(len_byte);
        foreach (frame_data[i])
            send_byte(frame_data[i]);
        send_byte(check);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Brings the block back to hunting and idle, then writes the length register.
    task automatic set_length(input logic [5:0] v);
        while (rx_phase != PH_HUNT)
            send_byte(8'hFF);
        wait_drained();
        cfg_valid <= 1'b1;
        expected_length <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_length = v;
    endtask

    task automatic set_idling(input int gap_p, input int stall_p);
        gap_pct = gap_p;
        stall_pct = stall_p;
    endtask

    task automatic send_random_frame();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 8)
            repeat ($urandom_range(4, 1)) send_byte(rand_byte());
        else if (r < 15)
        begin
            send_byte(SYNC_FIRST);
            send_byte(($urandom_range(3) == 0) ? SYNC_FIRST : rand_byte());
        end
        else if (r < 22)
        begin
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
            send_byte(rand_byte());
        end
        else
        begin
            n = (cfg_length > RESULT_LIMIT) ? 0 : cfg_length;
            frame_data.delete();
            repeat (n) frame_data.push_back(rand_byte());
            send_frame({2'b00, cfg_length}, r < 37);
        end
    endtask

    // Length register still holds its reset value of zero here.
    task automatic test_reset_and_hunt();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_SECOND);
        frame_data.delete();
        send_frame(8'd0, 1'b0);
        send_frame(8'd0, 1'b1);
    endtask

    task automatic test_header_errors();
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        // A repeated sync byte is consumed as a bad second sync.
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'd5);
    endtask

    task automatic test_short_frame();
        set_length(6'd3);
        frame_data = '{8'h00, 8'hFF, 8'h80};
        send_frame(8'd3, 1'b0);
    endtask

    // Lengths past the buffer are refused even when the length byte agrees.
    task automatic test_oversize_length();
        set_length(6'd63);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'd63);
        set_length(6'd33);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'd33);
    endtask

    task automatic test_random_traffic();
        int lens [10];
        int p;
        int start_items;
        lens = '{32, 0, 1, 63, 5, 33, 2, 3, 8, 31};
        p = 0;
        while (framed_items < TOTAL_ITEMS)
        begin
            set_length(6'(lens[p % 10]));
            case (p % 3)
                0: set_idling(0, 0);
                1: set_idling(25, 25);
                default: set_idling(60, 50);
            endcase
            start_items = framed_items;
            while (framed_items - start_items < PHASE_ITEMS && framed_items < TOTAL_ITEMS)
                send_random_frame();
            p++;
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            stall_left <= ($urandom_range(11) == 0) ? $urandom_range(40, 15) : $urandom_range(2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        rx_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, status", 0, status);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", want.st, status);
                if (has_data !== want.has_data)
                    report_mismatch("has_data", want.has_data, has_data);
                if (payload_byte !== want.data)
                    report_mismatch("payload_byte", want.data, payload_byte);
                if (byte_index !== want.idx)
                    report_mismatch("byte_index", want.idx, byte_index);
                if (last !== want.last)
                    report_mismatch("last", want.last, last);
            end
        end
    end

    // Any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(20, 20);
        test_reset_and_hunt();
        test_header_errors();
        test_short_frame();
        test_oversize_length();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* framed_packet_receiver_xor_unit.f */
rtl/core/fprx_pkg.sv
rtl/core/fprx_payload_buf.sv
rtl/core/fprx_frame_ctrl.sv
rtl/core/fprx_out_seq.sv
rtl/core/framed_packet_receiver_xor_unit.sv
sim/tb_top.sv
